### src/crgm_pkg.sv
// shared constants and types of the colour ramp gradient map
package crgm_pkg;

  localparam int unsigned MaxStopsDef = 7;
  localparam int unsigned StopW       = 48;
  localparam int unsigned PosW        = 16;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned ColW        = 32;
  localparam int unsigned CountW      = 3;
  localparam int unsigned NumW        = 24;
  localparam int unsigned QuotW       = 8;
  localparam int unsigned MidDepth    = 4;
  localparam int unsigned NarrowLimit = 7;

  localparam logic [15:0] WRed   = 16'd19595;
  localparam logic [15:0] WGreen = 16'd38470;
  localparam logic [15:0] WBlue  = 16'd7471;

  localparam logic [ColW-1:0]  BlackColor    = 32'h0000_00FF;
  localparam logic [StopW-1:0] Stop0Reset    = 48'h0000_0000_00FF;
  localparam logic [StopW-1:0] Stop1Reset    = 48'hFFFF_FFFF_FFFF;
  localparam logic [StopW-1:0] StopRest      = 48'h0;
  localparam logic [CountW-1:0] CountReset   = 3'd2;

  localparam int unsigned RegStopCount = 0;
  localparam int unsigned RegStop0     = 1;

  // one colour pair and segment handed from front to back
  typedef struct packed {
    logic [ColW-1:0] c0;
    logic [ColW-1:0] c1;
    logic [PosW-1:0] r;
    logic [PosW-1:0] d;
  } crgm_item_t;

endpackage

### src/crgm_fifo.sv
// small register queue between front and back
module crgm_fifo #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### src/crgm_front.sv
// front end: factor, luminance and segment search
module crgm_front #(
  parameter int unsigned MaxStops = crgm_pkg::MaxStopsDef
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      push_i,
  output logic                                      full_o,
  input  logic                                      fac_is_color_i,
  input  logic [crgm_pkg::PosW-1:0]                 fac_value_i,
  input  logic [crgm_pkg::ChanW-1:0]                in_red_i,
  input  logic [crgm_pkg::ChanW-1:0]                in_green_i,
  input  logic [crgm_pkg::ChanW-1:0]                in_blue_i,
  input  logic [crgm_pkg::CountW-1:0]               stop_count_i,
  input  logic [MaxStops-1:0][crgm_pkg::StopW-1:0]  stops_i,
  output logic                                      q_push_o,
  output crgm_pkg::crgm_item_t                      q_item_o,
  input  logic                                      q_full_i
);

  localparam int unsigned IdxW = $clog2(MaxStops);

  logic                        en;
  logic                        v1_q, v2_q, v3_q;
  logic                        sel_q;
  logic [crgm_pkg::PosW-1:0]   fv_q;
  logic [31:0]                 pr_q, pg_q, pb_q;
  logic [crgm_pkg::PosW-1:0]   fac_q, fac_d;
  logic [33:0]                 sum;
  logic [17:0]                 lum;
  crgm_pkg::crgm_item_t        item_q, item_d;

  logic [crgm_pkg::CountW-1:0] n;
  logic [IdxW-1:0]             last_idx;
  logic [crgm_pkg::PosW-1:0]   p0, p1;
  logic [crgm_pkg::ColW-1:0]   c0, c1;
  logic                        found;

  assign en       = !(v3_q && q_full_i);
  assign full_o   = !en;
  assign q_push_o = v3_q && !q_full_i;
  assign q_item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_q  <= fac_is_color_i;
      fv_q   <= fac_value_i;
      pr_q   <= 32'(crgm_pkg::WRed)   * 32'({in_red_i, in_red_i});
      pg_q   <= 32'(crgm_pkg::WGreen) * 32'({in_green_i, in_green_i});
      pb_q   <= 32'(crgm_pkg::WBlue)  * 32'({in_blue_i, in_blue_i});
      fac_q  <= fac_d;
      item_q <= item_d;
    end
  end

  // rounded luminance, saturated
  always_comb begin
    sum = 34'(pr_q) + 34'(pg_q) + 34'(pb_q) + 34'd32768;
    lum = sum[33:16];
    if (!sel_q) begin
      fac_d = fv_q;
    end else if (lum > 18'd65535) begin
      fac_d = '1;
    end else begin
      fac_d = lum[15:0];
    end
  end

  always_comb begin
    n        = (stop_count_i > crgm_pkg::CountW'(MaxStops))
               ? crgm_pkg::CountW'(MaxStops) : stop_count_i;
    last_idx = IdxW'(n - 1'b1);
    found    = 1'b0;
    p0       = '0;
    p1       = '0;
    c0       = '0;
    c1       = '0;
    // descending so the first enclosing segment wins
    for (int i = MaxStops - 2; i >= 0; i--) begin
      if ((i + 1 < int'(n)) && (fac_q >= stops_i[i][47:32]) &&
          (fac_q <= stops_i[i+1][47:32])) begin
        found = 1'b1;
        p0    = stops_i[i][47:32];
        p1    = stops_i[i+1][47:32];
        c0    = stops_i[i][31:0];
        c1    = stops_i[i+1][31:0];
      end
    end

    item_d.c1 = '0;
    item_d.r  = crgm_pkg::PosW'(1);
    item_d.d  = '0;
    item_d.c0 = crgm_pkg::BlackColor;
    if (n == '0) begin
      item_d.c0 = crgm_pkg::BlackColor;
    end else if (n == crgm_pkg::CountW'(1)) begin
      item_d.c0 = stops_i[0][31:0];
    end else if (found) begin
      if ((p1 - p0) < crgm_pkg::PosW'(crgm_pkg::NarrowLimit)) begin
        item_d.c0 = c0;
      end else begin
        item_d.c0 = c0;
        item_d.c1 = c1;
        item_d.r  = p1 - p0;
        item_d.d  = fac_q - p0;
      end
    end else if (fac_q < stops_i[0][47:32]) begin
      item_d.c0 = stops_i[0][31:0];
    end else if (fac_q > stops_i[last_idx][47:32]) begin
      item_d.c0 = stops_i[last_idx][31:0];
    end
  end

endmodule

### src/crgm_back.sv
// back end: weighted sums and pipelined division per channel
module crgm_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  crgm_pkg::crgm_item_t              q_item_i,
  output logic                              q_pop_o,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic [3:0][crgm_pkg::ChanW-1:0]   color_o
);

  localparam int unsigned NumW  = crgm_pkg::NumW;
  localparam int unsigned QuotW = crgm_pkg::QuotW;
  localparam int unsigned PosW  = crgm_pkg::PosW;

  logic                         en;
  logic [QuotW:0]               v_q;
  logic [3:0][NumW-1:0]         rem_q [QuotW+1];
  logic [3:0][QuotW-1:0]        quo_q [QuotW+1];
  logic [PosW-1:0]              dv_q  [QuotW+1];
  logic [3:0][NumW-1:0]         num_d;
  logic [3:0][NumW-1:0]         rem_d [QuotW];
  logic [3:0][QuotW-1:0]        quo_d [QuotW];
  logic [NumW-1:0]              sub   [QuotW];

  assign en      = !v_q[QuotW] || pop_i;
  assign empty_o = !v_q[QuotW];
  assign q_pop_o = en && !q_empty_i;
  assign color_o = quo_q[QuotW];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      num_d[k] = NumW'(NumW'(q_item_i.c0[31-8*k -: 8]) * NumW'(q_item_i.r - q_item_i.d))
               + NumW'(NumW'(q_item_i.c1[31-8*k -: 8]) * NumW'(q_item_i.d))
               + NumW'(q_item_i.r >> 1);
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int j = 0; j < QuotW; j++) begin
      sub[j] = NumW'(dv_q[j]) << (QuotW - 1 - j);
      for (int k = 0; k < 4; k++) begin
        if (rem_q[j][k] >= sub[j]) begin
          rem_d[j][k] = rem_q[j][k] - sub[j];
          quo_d[j][k] = {quo_q[j][k][QuotW-2:0], 1'b1};
        end else begin
          rem_d[j][k] = rem_q[j][k];
          quo_d[j][k] = {quo_q[j][k][QuotW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[QuotW-1:0], !q_empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= num_d;
      quo_q[0] <= '0;
      dv_q[0]  <= q_item_i.r;
      for (int j = 0; j < QuotW; j++) begin
        rem_q[j+1] <= rem_d[j];
        quo_q[j+1] <= quo_d[j];
        dv_q[j+1]  <= dv_q[j];
      end
    end
  end

endmodule

### src/color_ramp_gradient_map.sv
// top level of the colour ramp gradient map
// Maps each beat (a 16-bit factor or the luminance of an RGB pixel) to an
// RGBA colour through up to MAX_STOPS stops written in ascending order of
// position. One beat is accepted and one result leaves per clock, unless
// stalled by full or by a result waiting for pop; push to result passes three
// front stages, one queue slot, one product stage and an eight-stage divider.
// A four-beat queue between the segment search and the divider lets either side
// stall alone. The user writes stops and the count only while idle (not enforced).
module color_ramp_gradient_map #(
  parameter int unsigned MAX_STOPS = crgm_pkg::MaxStopsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [$clog2(MAX_STOPS+1)-1:0]    cfg_idx_i,
  input  logic [crgm_pkg::StopW-1:0]        cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  logic                              fac_is_color_i,
  input  logic [crgm_pkg::PosW-1:0]         fac_value_i,
  input  logic [crgm_pkg::ChanW-1:0]        in_red_i,
  input  logic [crgm_pkg::ChanW-1:0]        in_green_i,
  input  logic [crgm_pkg::ChanW-1:0]        in_blue_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [crgm_pkg::ChanW-1:0]        out_red_o,
  output logic [crgm_pkg::ChanW-1:0]        out_green_o,
  output logic [crgm_pkg::ChanW-1:0]        out_blue_o,
  output logic [crgm_pkg::ChanW-1:0]        out_alpha_o
);

  localparam int unsigned CfgW = $clog2(MAX_STOPS + 1);
  localparam int unsigned ItemW = $bits(crgm_pkg::crgm_item_t);

  logic [crgm_pkg::CountW-1:0]                 count_q;
  logic [MAX_STOPS-1:0][crgm_pkg::StopW-1:0]   stops_q;
  logic                                        mid_push, mid_full, mid_pop, mid_empty;
  crgm_pkg::crgm_item_t                        mid_wdata, mid_rdata;
  logic [3:0][crgm_pkg::ChanW-1:0]             color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= crgm_pkg::CountReset;
      for (int i = 0; i < MAX_STOPS; i++) begin
        if (i == 0) begin
          stops_q[i] <= crgm_pkg::Stop0Reset;
        end else if (i == 1) begin
          stops_q[i] <= crgm_pkg::Stop1Reset;
        end else begin
          stops_q[i] <= crgm_pkg::StopRest;
        end
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgW'(crgm_pkg::RegStopCount)) begin
        count_q <= cfg_data_i[crgm_pkg::CountW-1:0];
      end
      for (int i = 0; i < MAX_STOPS; i++) begin
        if (cfg_idx_i == CfgW'(crgm_pkg::RegStop0 + i)) begin
          stops_q[i] <= cfg_data_i;
        end
      end
    end
  end

  crgm_front #(
    .MaxStops(MAX_STOPS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i         (push),
    .full_o         (full),
    .fac_is_color_i,
    .fac_value_i,
    .in_red_i,
    .in_green_i,
    .in_blue_i,
    .stop_count_i   (count_q),
    .stops_i        (stops_q),
    .q_push_o       (mid_push),
    .q_item_o       (mid_wdata),
    .q_full_i       (mid_full)
  );

  crgm_fifo #(
    .Width(ItemW),
    .Depth(crgm_pkg::MidDepth)
  ) u_mid (
    .clk_i,
    .rst_ni,
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  crgm_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (mid_empty),
    .q_item_i  (mid_rdata),
    .q_pop_o   (mid_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .color_o   (color)
  );

  assign out_red_o   = color[0];
  assign out_green_o = color[1];
  assign out_blue_o  = color[2];
  assign out_alpha_o = color[3];

  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> mid_full)
    else $error("front stalled with room in the mid queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && !pop) |=> $stable(color))
    else $error("waiting result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni) mid_pop |-> !mid_empty)
    else $error("pop from empty mid queue");

endmodule

### tb/crgm_checker.sv
// checker for the colour ramp gradient map: predicts each colour and compares result beats
`timescale 1ns / 100ps
module crgm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        push,
  input  logic        full,
  input  logic        fac_is_color_i,
  input  logic [15:0] fac_value_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  input  logic        pop,
  input  logic        empty,
  input  logic [7:0]  out_red_o,
  input  logic [7:0]  out_green_o,
  input  logic [7:0]  out_blue_o,
  input  logic [7:0]  out_alpha_o,
  output int          fail_count_o,
  output int          pending_o
);
  import crgm_pkg::*;

  logic [CountW-1:0] stop_num;
  logic [StopW-1:0]  stops [MaxStopsDef];
  logic [ColW-1:0]   colour_q [$];
  int                fails;

  assign fail_count_o = fails;
  assign pending_o    = colour_q.size();

  function automatic logic [ColW-1:0] blend(logic [StopW-1:0] s0, logic [StopW-1:0] s1,
                                            int unsigned r, int unsigned d);
    logic [ColW-1:0] res;
    longint unsigned c0, c1;
    for (int k = 0; k < 4; k++) begin
      c0 = s0[24-8*k +: 8];
      c1 = s1[24-8*k +: 8];
      res[24-8*k +: 8] = 8'((c0 * (r - d) + c1 * d + r / 2) / r);
    end
    return res;
  endfunction

  function automatic logic [ColW-1:0] ramp_colour(logic is_col, logic [15:0] v,
                                                  logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned sum;
    int unsigned fac, n, p0, p1;
    if (is_col) begin
      sum = longint'(WRed) * r * 257 + longint'(WGreen) * g * 257
          + longint'(WBlue) * b * 257;
      sum = (sum + 32768) >> 16;
      fac = (sum > 65535) ? 65535 : int'(sum);
    end else begin
      fac = v;
    end
    n = (stop_num > MaxStopsDef) ? MaxStopsDef : stop_num;
    if (n == 0) return BlackColor;
    if (n == 1) return stops[0][ColW-1:0];
    for (int i = 0; i + 1 < n; i++) begin
      p0 = stops[i][47:32];
      p1 = stops[i+1][47:32];
      if (fac >= p0 && fac <= p1) begin
        if (p1 - p0 < NarrowLimit) return stops[i][ColW-1:0];
        return blend(stops[i], stops[i+1], p1 - p0, fac - p0);
      end
    end
    if (fac < stops[0][47:32]) return stops[0][ColW-1:0];
    if (fac > stops[n-1][47:32]) return stops[n-1][ColW-1:0];
    return BlackColor;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [ColW-1:0] want, got;
    if (!rst_ni) begin
      stop_num <= CountReset;
      stops[0] <= Stop0Reset;
      stops[1] <= Stop1Reset;
      for (int i = 2; i < MaxStopsDef; i++) stops[i] <= StopRest;
      colour_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegStopCount) stop_num <= cfg_data_i[CountW-1:0];
        else stops[cfg_idx_i - RegStop0] <= cfg_data_i;
      end
      if (push && !full)
        colour_q.push_back(ramp_colour(fac_is_color_i, fac_value_i, in_red_i, in_green_i,
                                       in_blue_i));
      if (pop && !empty) begin
        got = {out_red_o, out_green_o, out_blue_o, out_alpha_o};
        if (colour_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = colour_q.pop_front();
          if (want !== got) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected r%h g%h b%h a%h, got r%h g%h b%h a%h",
                       want[31:24], want[23:16], want[15:8], want[7:0],
                       got[31:24], got[23:16], got[15:8], got[7:0]);
          end
        end
      end
    end
  end
endmodule

### tb/tb_color_ramp_gradient_map.sv
// testbench top of the colour ramp gradient map: stimulus, config phases and verdict
`timescale 1ns / 100ps
module tb_color_ramp_gradient_map;
  import crgm_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int HoldCycles = 400;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [47:0] cfg_data_i;
  logic        push, full, pop, empty;
  logic        fac_is_color_i;
  logic [15:0] fac_value_i;
  logic [7:0]  in_red_i, in_green_i, in_blue_i;
  logic [7:0]  out_red_o, out_green_o, out_blue_o, out_alpha_o;
  int          fail_count, pending;
  int          idle_cycles;
  int          popped;
  bit          calm;
  bit          hold_done;
  int unsigned stop_pos [MaxStopsDef];

  color_ramp_gradient_map u_top (.*);

  crgm_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .push, .full,
    .fac_is_color_i, .fac_value_i, .in_red_i, .in_green_i, .in_blue_i,
    .pop, .empty, .out_red_o, .out_green_o, .out_blue_o, .out_alpha_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (push && !full || pop && !empty) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side
  initial begin
    int w;
    pop <= 1'b0;
    popped = 0;
    hold_done = 1'b0;
    calm = 1'b0;
    wait (rst_ni);
    forever begin
      if (!hold_done && popped == 150) begin
        hold_done = 1'b1;
        calm = 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        calm = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        pop <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(negedge clk_i);
      while (empty) @(negedge clk_i);
      @(posedge clk_i);
      popped++;
    end
  end

  task automatic send_beat(logic is_col, logic [15:0] v, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b);
    int w;
    w = calm ? 0 : $urandom_range(0, 14);
    if (w > 0) begin
      push <= 1'b0;
      repeat (w) @(posedge clk_i);
    end
    push           <= 1'b1;
    fac_is_color_i <= is_col;
    fac_value_i    <= v;
    in_red_i       <= r;
    in_green_i     <= g;
    in_blue_i      <= b;
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx != RegStopCount) stop_pos[idx - RegStop0] = data[47:32];
    @(posedge clk_i);
  endtask

  task automatic settle;
    push     <= 1'b0;
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic load_stops(int unsigned num, bit sorted, int unsigned spread);
    int unsigned pos [$];
    logic [31:0] col;
    for (int i = 0; i < MaxStopsDef; i++) pos.push_back($urandom_range(0, spread));
    if (sorted) pos.sort();
    for (int i = 0; i < MaxStopsDef; i++) begin
      col = $urandom();
      write_reg(3'(RegStop0 + i), {16'(pos[i]), col});
    end
    write_reg(3'(RegStopCount), 48'(num));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_beats(int count, int unsigned num);
    int unsigned v;
    for (int i = 0; i < count; i++) begin
      if (num > 0 && $urandom_range(0, 2) == 0)
        v = stop_pos[$urandom_range(0, (num > 7 ? 7 : num) - 1)] + $urandom_range(0, 6) - 3;
      else
        v = $urandom();
      send_beat(1'($urandom_range(0, 1)), 16'(v), 8'($urandom()), 8'($urandom()),
                8'($urandom()));
    end
  endtask

  initial begin
    int unsigned num;
    rst_ni         = 1'b0;
    push           = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    fac_is_color_i = 1'b0;
    fac_value_i    = '0;
    in_red_i       = '0;
    in_green_i     = '0;
    in_blue_i      = '0;
    stop_pos[0]    = 0;
    stop_pos[1]    = 16'hFFFF;
    for (int i = 2; i < MaxStopsDef; i++) stop_pos[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset ramp, extremes of factor and pixel
    send_beat(1'b0, 16'h0000, 8'h00, 8'h00, 8'h00);
    send_beat(1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_beat(1'b0, 16'h8000, 8'h55, 8'hAA, 8'h55);
    send_beat(1'b0, 16'h7FFF, 8'hAA, 8'h55, 8'hAA);
    send_beat(1'b1, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    send_beat(1'b1, 16'h0000, 8'hFF, 8'hFF, 8'hFF);
    send_beat(1'b1, 16'h1234, 8'hFF, 8'h00, 8'h00);
    send_beat(1'b1, 16'h1234, 8'h00, 8'hFF, 8'h00);
    send_beat(1'b1, 16'h1234, 8'h00, 8'h00, 8'hFF);
    settle();

    // no stops, one stop
    write_reg(3'(RegStopCount), 48'd0);
    cfg_we_i <= 1'b0;
    send_beat(1'b0, 16'h4000, 8'h00, 8'h00, 8'h00);
    send_beat(1'b1, 16'h0000, 8'h80, 8'h80, 8'h80);
    settle();
    write_reg(3'(RegStop0), 48'h8000_1234_5678);
    write_reg(3'(RegStopCount), 48'd1);
    cfg_we_i <= 1'b0;
    send_beat(1'b0, 16'h0000, 8'h00, 8'h00, 8'h00);
    send_beat(1'b0, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    settle();

    // narrow segment, below first and above last stop
    write_reg(3'(RegStop0), 48'h1000_FF00_00FF);
    write_reg(3'(RegStop0 + 1), 48'h1005_00FF_0000);
    write_reg(3'(RegStop0 + 2), 48'h1006_0000_FF80);
    write_reg(3'(RegStop0 + 3), 48'hF000_FFFF_FFFF);
    write_reg(3'(RegStopCount), 48'd4);
    cfg_we_i <= 1'b0;
    send_beat(1'b0, 16'h0FFF, 8'h00, 8'h00, 8'h00);
    send_beat(1'b0, 16'h1003, 8'h00, 8'h00, 8'h00);
    send_beat(1'b0, 16'h1005, 8'h00, 8'h00, 8'h00);
    send_beat(1'b0, 16'h8000, 8'h00, 8'h00, 8'h00);
    send_beat(1'b0, 16'hF001, 8'h00, 8'h00, 8'h00);
    send_beat(1'b0, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    settle();

    // count field at the stop limit, all seven stops in use
    for (int i = 0; i < MaxStopsDef; i++)
      write_reg(3'(RegStop0 + i), {16'(i * 10000), 32'($urandom())});
    write_reg(3'(RegStopCount), 48'h7);
    cfg_we_i <= 1'b0;
    random_beats(8, 7);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      num = (ph == 0) ? 7 : (ph == 1) ? 0 : (ph == 2) ? 1 : $urandom_range(0, 7);
      load_stops(num, ph != 3, (ph % 3 == 2) ? 40 : 65535);
      random_beats(55, num);
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
